@@ sv/lzss_bitstream_decompressor_assert.svh @@
// Assertion macros for the LZSS bitstream decompressor.
// Expects signals named clock and reset in the module that uses them.
`ifndef LZSS_BITSTREAM_DECOMPRESSOR_ASSERT_SVH
`define LZSS_BITSTREAM_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, off during reset
`define LZBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define LZBD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lzbd_pkg.sv @@
// Shared types, constants and helpers of the LZSS bitstream decompressor.
// No dependencies.
package lzbd_pkg;

   localparam int DICT_SIZE  = 4096;
   localparam int DICT_AW    = $clog2(DICT_SIZE);
   localparam int FILL_W     = DICT_AW + 1;
   localparam int ACC_W      = 24;
   localparam int AVAIL_W    = 5;
   localparam int LIT_BITS   = 9;
   localparam int COPY_BITS  = 17;
   localparam int TOTAL_W    = 24;
   localparam int LEN_W      = 4;
   localparam int REMAIN_W   = LEN_W + 1;

   typedef struct packed {
      logic               rd_en;
      logic [DICT_AW-1:0] rd_addr;
      logic               wr_en;
      logic [7:0]         wr_data;
   } dict_req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               last;
      logic               stream_end;
      logic [TOTAL_W-1:0] total_bytes;
   } result_type;

   // True when the pending bits (right-aligned, oldest highest) hold a whole token
   function automatic logic token_complete(input logic [ACC_W-1:0] acc,
                                           input logic [AVAIL_W-1:0] avail);
      logic flag;
      logic ok;
      flag = 1'b0;
      ok   = 1'b0;
      if (avail != '0) begin
         flag = acc[avail - AVAIL_W'(1)];
         ok   = flag ? (avail >= AVAIL_W'(LIT_BITS)) : (avail >= AVAIL_W'(COPY_BITS));
      end
      return ok;
   endfunction

endpackage

@@ sv/lzbd_req_if.sv @@
// Compressed byte channel of the LZSS bitstream decompressor.
// No dependencies.
interface lzbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/lzbd_rsp_if.sv @@
// Result channel of the LZSS bitstream decompressor.
// No dependencies.
interface lzbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        last;
   logic        stream_end;
   logic [23:0] total_bytes;

   modport source (output valid, output out_byte, output byte_valid, output last,
                   output stream_end, output total_bytes, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last,
                   input stream_end, input total_bytes, output ready);
endinterface

@@ sv/lzbd_dict.sv @@
// History memory of the decompressor: 4096 x 8 synchronous RAM, append pointer
// and fill count. Depends on lzbd_pkg.
module lzbd_dict (
   input  logic                  clock,
   input  logic                  reset,
   input  lzbd_pkg::dict_req_type req,
   output logic [7:0]            rd_data
);
   import lzbd_pkg::*;

   logic [7:0]         mem [DICT_SIZE];
   logic [DICT_AW-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [7:0]         rd_data_ff;
   logic               rd_hit_ff;
   logic [DICT_AW-1:0] rel_addr;
   logic               hit;

   // Writes run upward from entry 1, so an entry is written once its distance
   // from entry 1 falls below the fill count; unwritten entries read as zero.
   assign rel_addr = req.rd_addr - DICT_AW'(1);
   assign hit      = {1'b0, rel_addr} < fill_ff;

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (req.wr_en) begin
         wp_in = wp_ff + DICT_AW'(1);
         if (fill_ff != FILL_W'(DICT_SIZE)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= DICT_AW'(1);
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[wp_ff] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
         rd_hit_ff  <= hit;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : 8'd0;

endmodule

@@ sv/lzbd_seq.sv @@
// Bit parser and copy sequencer of the decompressor: splits tokens out of the
// bit stream and drives the history memory. Depends on lzbd_pkg and the assert header.
`include "lzss_bitstream_decompressor_assert.svh"

module lzbd_seq #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   output logic                   in_ready,
   input  logic                   emit_ok,
   output logic                   res_valid,
   output lzbd_pkg::result_type   res,
   output lzbd_pkg::dict_req_type dict_req,
   input  logic [7:0]             dict_data
);
   import lzbd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [AVAIL_W-1:0]     avail_ff, avail_in;
   logic [DICT_AW-1:0]     src_ff, src_in;
   logic [REMAIN_W-1:0]    remain_ff, remain_in;
   logic                   finished_ff, finished_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic [ACC_W-1:0]             top;
   logic                         flag;
   logic [7:0]                   lit;
   logic [DICT_AW-1:0]           offs;
   logic [LEN_W-1:0]             len;
   logic [AVAIL_W-1:0]           rest_lit, rest_copy;
   logic [COUNT_WIDTH-1:0]       count_inc;
   logic [COUNT_WIDTH+TOTAL_W-1:0] count_ext;
   logic                         end_taken;

   // oldest pending bit moved to the top
   assign top       = acc_ff << (AVAIL_W'(ACC_W) - avail_ff);
   assign flag      = top[ACC_W-1];
   assign lit       = top[ACC_W-2 -: 8];
   assign offs      = top[ACC_W-2 -: DICT_AW];
   assign len       = top[ACC_W-2-DICT_AW -: LEN_W];
   assign rest_lit  = avail_ff - AVAIL_W'(LIT_BITS);
   assign rest_copy = avail_ff - AVAIL_W'(COPY_BITS);
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
   assign count_ext = {{TOTAL_W{1'b0}}, count_ff};

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      avail_in    = avail_ff;
      src_in      = src_ff;
      remain_in   = remain_ff;
      finished_in = finished_ff;
      count_in    = count_ff;
      in_ready    = (state_ff == ST_IDLE);
      res_valid   = 1'b0;
      res         = '0;
      dict_req    = '0;
      end_taken   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // once finished, items are taken and dropped
            if (in_valid && !finished_ff) begin
               acc_in   = {acc_ff[ACC_W-9:0], in_byte};
               avail_in = avail_ff + AVAIL_W'(8);
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (avail_ff == '0) begin
               state_in = ST_IDLE;
            end else if (flag) begin
               if (avail_ff < AVAIL_W'(LIT_BITS)) begin
                  state_in = ST_IDLE;
               end else begin
                  res_valid      = 1'b1;
                  res.out_byte   = lit;
                  res.byte_valid = 1'b1;
                  res.last       = !token_complete(acc_ff, rest_lit);
                  if (emit_ok) begin
                     dict_req.wr_en   = 1'b1;
                     dict_req.wr_data = lit;
                     avail_in         = rest_lit;
                     count_in         = count_inc;
                  end
               end
            end else if (avail_ff < AVAIL_W'(COPY_BITS)) begin
               state_in = ST_IDLE;
            end else if (offs == '0) begin
               // end marker: trailing bits are dropped
               res_valid       = 1'b1;
               res.last        = 1'b1;
               res.stream_end  = 1'b1;
               res.total_bytes = count_ext[TOTAL_W-1:0];
               if (emit_ok) begin
                  end_taken   = 1'b1;
                  finished_in = 1'b1;
                  avail_in    = '0;
                  state_in    = ST_IDLE;
               end
            end else begin
               src_in    = offs;
               remain_in = {1'b0, len} + REMAIN_W'(1);
               avail_in  = rest_copy;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            dict_req.rd_en   = 1'b1;
            dict_req.rd_addr = src_ff;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            // the previous write has landed before this entry was read,
            // so overlapping copies see their own output
            res_valid      = 1'b1;
            res.out_byte   = dict_data;
            res.byte_valid = 1'b1;
            res.last       = (remain_ff == '0) && !token_complete(acc_ff, avail_ff);
            if (emit_ok) begin
               dict_req.wr_en   = 1'b1;
               dict_req.wr_data = dict_data;
               count_in         = count_inc;
               src_in           = src_ff + DICT_AW'(1);
               if (remain_ff == '0) begin
                  state_in = ST_DECODE;
               end else begin
                  remain_in = remain_ff - REMAIN_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         acc_ff      <= '0;
         avail_ff    <= '0;
         finished_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         acc_ff      <= acc_in;
         avail_ff    <= avail_in;
         finished_ff <= finished_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      remain_ff <= remain_in;
   end

   `LZBD_ASSERT_IMPLY(a_idle_pending, state_ff == ST_IDLE, avail_ff <= AVAIL_W'(16), "more than 16 bits pending while idle")
   `LZBD_ASSERT_IMPLY(a_no_rw_same, dict_req.rd_en, !dict_req.wr_en, "history read and write in one cycle")
   `LZBD_ASSERT_IMPLY(a_emit_order, state_ff == ST_EMIT, $past(state_ff) == ST_READ || $past(state_ff) == ST_EMIT, "copy emit without a read")
   `LZBD_ASSERT_NEXT(a_end_sticks, end_taken, finished_ff && state_ff == ST_IDLE, "end marker did not stop decoding")

endmodule

@@ sv/lzss_bitstream_decompressor.sv @@
// A literal passes DECODE and the output register to rsp; a copy byte passes DECODE, READ,
// EMIT and the output register. Items are taken only in IDLE, after every complete token
// is done; each literal, end marker and copy token takes a DECODE step, each copied byte a
// READ and an EMIT step; the history RAM (read, then write back) sets the copy rate.
// Reset (synchronous): control clears, write pointer to 1; the RAM is not swept, a fill
// count makes unwritten entries read as zero, so items are taken at once.
// Top level of the LZSS bitstream decompressor: channels, output register, sequencer and
// history memory. Depends on lzbd_pkg, lzbd_req_if, lzbd_rsp_if, lzbd_seq, lzbd_dict.
module lzss_bitstream_decompressor #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic         clock,
   input  logic         reset,
   lzbd_req_if.sink     req_chan,
   lzbd_rsp_if.source   rsp_chan
);
   import lzbd_pkg::*;

   // handshake between sequencer and output register
   logic         emit_ok;
   logic         res_valid;
   result_type   res;

   // history memory port
   dict_req_type dict_req;
   logic [7:0]   dict_data;

   // output register: holds one result until taken; the next result waits while it is full and rsp is not ready
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff, rsp_data_in;

   assign emit_ok = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_data_ff.out_byte;
   assign rsp_chan.byte_valid  = rsp_data_ff.byte_valid;
   assign rsp_chan.last        = rsp_data_ff.last;
   assign rsp_chan.stream_end  = rsp_data_ff.stream_end;
   assign rsp_chan.total_bytes = rsp_data_ff.total_bytes;

   // token parser and copy sequencer
   lzbd_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_byte   (req_chan.in_byte),
      .in_ready  (req_chan.ready),
      .emit_ok   (emit_ok),
      .res_valid (res_valid),
      .res       (res),
      .dict_req  (dict_req),
      .dict_data (dict_data)
   );

   // 4 KiB history, registered read
   lzbd_dict u_dict (
      .clock   (clock),
      .reset   (reset),
      .req     (dict_req),
      .rd_data (dict_data)
   );

endmodule

@@ tb/sv/tb_lzss_bitstream_decompressor.sv @@
// Testbench for lzss_bitstream_decompressor: builds token streams, packs them into items
// and checks every result against an in-bench decoder. Depends on lzbd_pkg, lzbd_req_if,
// lzbd_rsp_if and the block itself.
module tb_lzss_bitstream_decompressor;
   import lzbd_pkg::*;

   localparam int COUNT_W = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzbd_req_if req_bus ();
   lzbd_rsp_if rsp_bus ();

   lzss_bitstream_decompressor #(
      .COUNT_WIDTH (COUNT_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // ---------------------------------------------------------------------------------
   // Decoder state, kept apart from the block and updated on each accepted item
   // ---------------------------------------------------------------------------------
   logic [7:0]         dict_mem [DICT_SIZE];
   logic [11:0]        wr_ptr;
   logic [15:0]        bit_store;    // pending bits, right-aligned, oldest highest
   int                 bit_cnt;
   logic               stream_done;
   logic [COUNT_W-1:0] emit_count;

   result_type pending_results [$];  // decoded bytes and end marker still to arrive
   result_type step_results [$];     // results of the item being decoded

   int  fail_count  = 0;
   int  sent_items  = 0;
   bit  idling_on   = 1'b1;
   int  rsp_hold    = 0;             // long receiver stall, in cycles, when non-zero

   // Stimulus side: token bits not yet packed into an item, and the write pointer
   // as the generator sees it (runs ahead of the decoder)
   bit          tok_bits [$];
   logic [11:0] gen_ptr     = 12'd1;

   initial begin
      for (int i = 0; i < DICT_SIZE; i++) dict_mem[i] = 8'h00;
      wr_ptr      = 12'd1;
      bit_store   = '0;
      bit_cnt     = 0;
      stream_done = 1'b0;
      emit_count  = '0;
   end

   // Appends one decoded byte to the history and to this item's results
   function automatic void record_byte(input logic [7:0] value);
      result_type r;
      dict_mem[wr_ptr] = value;
      wr_ptr = wr_ptr + 12'd1;
      if (emit_count != '1) emit_count = emit_count + 1'b1;
      r            = '0;
      r.out_byte   = value;
      r.byte_valid = 1'b1;
      step_results = {step_results, r};
   endfunction

   // Decodes one compressed item: joins it to the pending bits and runs every
   // token that is now complete
   task automatic decode_byte(input logic [7:0] value);
      logic [23:0] acc;
      int          avail;
      logic [15:0] word;
      logic [11:0] offs;
      int          len;
      result_type  r;
      if (stream_done) return;
      step_results.delete();
      acc   = {bit_store, value};
      avail = ((bit_cnt > 16) ? 16 : bit_cnt) + 8;
      while (avail >= 1) begin
         if (acc[avail-1]) begin
            if (avail < LIT_BITS) break;
            record_byte(8'(acc >> (avail - LIT_BITS)));
            avail -= LIT_BITS;
         end else begin
            if (avail < COPY_BITS) break;
            word  = 16'(acc >> (avail - COPY_BITS));
            avail -= COPY_BITS;
            offs  = word[15:4];
            if (offs == 12'd0) begin
               // end marker: count reported, remaining bits dropped
               r             = '0;
               r.stream_end  = 1'b1;
               r.total_bytes = TOTAL_W'(emit_count);
               step_results  = {step_results, r};
               stream_done = 1'b1;
               avail       = 0;
               break;
            end
            len = int'(word[3:0]) + 2;
            // byte by byte, so an overlapping copy sees its own output
            for (int j = 0; j < len; j++) record_byte(dict_mem[offs + 12'(j)]);
         end
      end
      bit_cnt   = avail;
      bit_store = 16'(acc & ((24'd1 << avail) - 24'd1));
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[k]) pending_results = {pending_results, step_results[k]};
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Clock, monitors and receiver
   // ---------------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // Outputs are sampled at the rising edge, before the block's own updates land
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) decode_byte(req_bus.in_byte);
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no decoded byte waiting: out_byte 0x%0h stream_end %0b",
                   rsp_bus.out_byte, rsp_bus.stream_end);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_byte", want.out_byte, rsp_bus.out_byte);
            check_field("byte_valid", want.byte_valid, rsp_bus.byte_valid);
            check_field("last", want.last, rsp_bus.last);
            check_field("stream_end", want.stream_end, rsp_bus.stream_end);
            check_field("total_bytes", want.total_bytes, rsp_bus.total_bytes);
         end
      end
   end

   // Receiver: random stall bursts, or one long hold-off when a test asks for it
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold - 1) @(negedge clock);
            rsp_hold = 0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Generous fixed limit, well above the slowest stalled run
   initial begin
      #5_000_000;
      $display("tb_lzss_bitstream_decompressor: errors");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Sender and token packing
   // ---------------------------------------------------------------------------------
   // Offers one item from the falling edge and holds it until taken; an idle
   // burst, if drawn, lowers valid first
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= value;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      sent_items++;
   endtask

   // Packs whole items out of the token bits, MSB first
   task automatic flush_bits();
      logic [7:0] b;
      while (tok_bits.size() >= 8) begin
         for (int i = 7; i >= 0; i--) b[i] = tok_bits.pop_front();
         send_byte(b);
      end
   endtask

   task automatic push_literal(input logic [7:0] value);
      tok_bits = {tok_bits, 1'b1};
      for (int i = 7; i >= 0; i--) tok_bits = {tok_bits, value[i]};
      gen_ptr = gen_ptr + 12'd1;
      flush_bits();
   endtask

   task automatic push_copy(input logic [11:0] offs, input logic [3:0] len);
      tok_bits = {tok_bits, 1'b0};
      for (int i = 11; i >= 0; i--) tok_bits = {tok_bits, offs[i]};
      for (int i = 3; i >= 0; i--) tok_bits = {tok_bits, len[i]};
      if (offs != 12'd0) begin
         gen_ptr = gen_ptr + 12'(len) + 12'd2;
      end
      flush_bits();
   endtask

   // Copy reaching just behind the write pointer, so it overlaps its own output
   function automatic logic [11:0] near_offset(input int back);
      logic [11:0] o;
      o = gen_ptr - 12'(back);
      return (o == 12'd0) ? 12'd1 : o;
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------
   // Literal extremes, shortest and longest copies, a copy over unwritten (zero)
   // entries, a source index wrapping past the top, and a run-length overlap.
   // Tokens straddle items, so some items complete nothing and others several.
   task automatic test_directed();
      push_literal(8'h00);
      push_literal(8'hFF);
      push_literal(8'hA5);
      push_literal(8'h5A);
      push_copy(12'd1, 4'd0);
      push_copy(12'd1, 4'hF);
      push_copy(near_offset(1), 4'hF);
      push_copy(12'hFFF, 4'hF);
      push_copy(12'h800, 4'd3);
      push_literal(8'h80);
      push_copy(near_offset(2), 4'd7);
   endtask

   // Receiver holds off for a long stretch while items keep coming, so the
   // block fills and stalls its input
   task automatic test_back_pressure();
      rsp_hold = 400;
      for (int i = 0; i < 12; i++) push_copy(12'($urandom_range(1, DICT_SIZE - 1)), 4'hF);
      for (int i = 0; i < 6; i++) push_literal(8'($urandom));
   endtask

   // Random tokens: mostly literals and copies, some overlapping copies and
   // shortest copies; the last stretch runs with no idling on either side
   task automatic test_random();
      int start;
      int pick;
      start = sent_items;
      while (sent_items - start < 100) begin
         if (sent_items - start >= 80) idling_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 45) push_literal(8'($urandom));
         else if (pick < 80) push_copy(12'($urandom_range(1, DICT_SIZE - 1)), 4'($urandom));
         else if (pick < 92) push_copy(near_offset($urandom_range(1, 4)), 4'($urandom));
         else push_copy(12'($urandom_range(1, DICT_SIZE - 1)), 4'd0);
      end
   endtask

   // End marker with random length bits, junk padding after it, then items
   // that must be ignored
   task automatic test_end_marker();
      push_literal(8'($urandom));
      push_copy(12'd0, 4'($urandom));
      while (tok_bits.size() % 8 != 0) tok_bits = {tok_bits, 1'($urandom)};
      for (int i = 0; i < 8; i++) tok_bits = {tok_bits, 1'($urandom)};
      flush_bits();
      for (int i = 0; i < 3; i++) send_byte(8'($urandom));
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_pressure();
      test_random();
      test_end_marker();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // room for anything the block might still send after the last result
      repeat (32) @(posedge clock);

      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb_lzss_bitstream_decompressor: clean");
      end else begin
         $display("tb_lzss_bitstream_decompressor: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/lzbd_pkg.sv
sv/lzbd_req_if.sv
sv/lzbd_rsp_if.sv
sv/lzbd_dict.sv
sv/lzbd_seq.sv
sv/lzss_bitstream_decompressor.sv
tb/sv/tb_lzss_bitstream_decompressor.sv
